// File: rtl/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg: shared types and constants for the touchpad packet decoder
// Field widths, packet kind codes, config register indexes and the word
// records passed between the issue, store and output stages.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int FINGER_COUNT_DEF = 5;

  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 3;
  localparam int POS_W   = 16;
  localparam int KIND_W  = 3;
  localparam int PRES_W  = 8;
  localparam int TW_W    = 4;
  localparam int MASK_W  = 5;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 12;
  localparam int YMAX_W    = 12;
  localparam int WEIGHT_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_CRC_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IC_BODY_VER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BYTE1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKPOINT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MAXIMUM     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_WEIGHT = 3'd5;

  localparam logic [WEIGHT_W-1:0] MOTION_WEIGHT_RST = 4'd5;

  // packet constants
  localparam logic [BYTE_W-1:0] SANE_MASK     = 8'h1c;
  localparam logic [BYTE_W-1:0] SANE_VALUE    = 8'h10;
  localparam logic [BYTE_W-1:0] SAMPLE_RELAX  = 8'h2A;
  localparam logic [3:0]        IC_VER_RELAX  = 4'd7;
  localparam logic [3:0]        TRACKPT_MARK  = 4'h6;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS     = 3'd0,
    KIND_HEAD       = 3'd1,
    KIND_MOTION     = 3'd2,
    KIND_UNKNOWN    = 3'd3,
    KIND_TRACKPOINT = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PTYPE_STATUS = 2'd0,
    PTYPE_HEAD   = 2'd1,
    PTYPE_MOTION = 2'd2,
    PTYPE_BAD    = 2'd3
  } ptype_t;

  typedef struct packed {
    logic                crc_mode;
    logic [3:0]          ic_body_version;
    logic [BYTE_W-1:0]   sample_byte_one;
    logic                trackpoint_present;
    logic [YMAX_W-1:0]   y_maximum;
    logic [WEIGHT_W-1:0] motion_weight;
  } cfg_t;

  // one store operation: absolute write (head) or delta update (motion)
  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  index;
    logic              store;
    logic              absolute;
    logic [POS_W-1:0]  dx;
    logic [POS_W-1:0]  dy;
    logic [PRES_W-1:0] pressure;
    logic [TW_W-1:0]   trace_width;
    logic [MASK_W-1:0] finger_mask;
    logic              last;
  } op_t;

  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  index;
    logic              updated;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [PRES_W-1:0] pressure;
    logic [TW_W-1:0]   trace_width;
    logic [MASK_W-1:0] finger_mask;
    logic              last;
  } res_t;

endpackage

// File: rtl/tpd_in_if.sv
// ----------------------------------------------------------------------------
// tpd_in_if: packet input channel
// Valid/ready channel carrying one six-byte packet per word.
// ----------------------------------------------------------------------------
interface tpd_in_if import tpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pkt_byte0;
  logic [BYTE_W-1:0] pkt_byte1;
  logic [BYTE_W-1:0] pkt_byte2;
  logic [BYTE_W-1:0] pkt_byte3;
  logic [BYTE_W-1:0] pkt_byte4;
  logic [BYTE_W-1:0] pkt_byte5;

  modport source (output valid, pkt_byte0, pkt_byte1, pkt_byte2, pkt_byte3,
                  pkt_byte4, pkt_byte5, input ready);
  modport sink   (input valid, pkt_byte0, pkt_byte1, pkt_byte2, pkt_byte3,
                  pkt_byte4, pkt_byte5, output ready);
endinterface

// File: rtl/tpd_out_if.sv
// ----------------------------------------------------------------------------
// tpd_out_if: result output channel
// Valid/ready channel carrying one decoded result per word.
// ----------------------------------------------------------------------------
interface tpd_out_if import tpd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        packet_kind;
  logic [IDX_W-1:0]         finger_index;
  logic                     position_updated;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [PRES_W-1:0]        pressure;
  logic [TW_W-1:0]          trace_width;
  logic [MASK_W-1:0]        finger_mask;
  logic                     last_of_packet;

  modport source (output valid, packet_kind, finger_index, position_updated, pos_x,
                  pos_y, pressure, trace_width, finger_mask, last_of_packet,
                  input ready);
  modport sink   (input valid, packet_kind, finger_index, position_updated, pos_x,
                  pos_y, pressure, trace_width, finger_mask, last_of_packet,
                  output ready);
endinterface

// File: rtl/tpd_issue.sv
// ----------------------------------------------------------------------------
// tpd_issue: packet holding register, classifier and operation issue
// Holds one packet, classifies it and issues one or two store operations, one
// per cycle while credit holds, with weighted motion deltas multiplied out.
// ----------------------------------------------------------------------------
module tpd_issue import tpd_pkg::*; #(
  parameter int FINGER_COUNT = FINGER_COUNT_DEF
) (
  input  logic   clk,
  input  logic   rst,
  tpd_in_if.sink pkt_in,
  input  cfg_t   cfg,
  input  logic   credit,
  output logic   op_valid,
  output op_t    op
);

  localparam logic [IDX_W-1:0] FC_CODE = IDX_W'(FINGER_COUNT);

  logic              pk_valid;
  logic              phase;
  logic [BYTE_W-1:0] b0, b1, b2, b3, b4, b5;

  logic                    accept;
  logic                    fire;
  logic                    trackpt;
  logic                    sane;
  ptype_t                  ptype;
  logic [IDX_W-1:0]        field;
  logic [IDX_W-1:0]        id;
  logic [BYTE_W-1:0]       dxb, dyb;
  logic [WEIGHT_W-1:0]     weight;
  logic signed [12:0]      dxw, dyw;

  // handshake: a new packet may enter as the last word of the held one issues
  assign fire         = pk_valid && credit;
  assign op_valid     = fire;
  assign accept       = pkt_in.valid && pkt_in.ready;
  assign pkt_in.ready = !pk_valid || (fire && op.last);

  // holding register control
  always_ff @(posedge clk) begin
    if (rst) begin
      pk_valid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      if (accept) begin
        pk_valid <= 1'b1;
        phase    <= 1'b0;
      end else if (fire) begin
        if (op.last) begin
          pk_valid <= 1'b0;
          phase    <= 1'b0;
        end else begin
          phase <= 1'b1;
        end
      end
    end
  end

  // packet bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      b0 <= pkt_in.pkt_byte0;
      b1 <= pkt_in.pkt_byte1;
      b2 <= pkt_in.pkt_byte2;
      b3 <= pkt_in.pkt_byte3;
      b4 <= pkt_in.pkt_byte4;
      b5 <= pkt_in.pkt_byte5;
    end
  end

  // classification
  always_comb begin
    trackpt = cfg.trackpoint_present && (b3[3:0] == TRACKPT_MARK);
    if (cfg.crc_mode) begin
      sane = !b3[3];
    end else if (cfg.ic_body_version == IC_VER_RELAX && cfg.sample_byte_one == SAMPLE_RELAX) begin
      sane = (b3 & SANE_MASK) == SANE_VALUE;
    end else begin
      sane = !b0[3] && ((b3 & SANE_MASK) == SANE_VALUE);
    end
    ptype = ptype_t'(b3[1:0]);
  end

  // finger field and delta bytes for the current phase
  always_comb begin
    field  = (ptype == PTYPE_MOTION && !phase) ? b0[7:5] : b3[7:5];
    id     = field - 3'd1;
    dxb    = phase ? b4 : b1;
    dyb    = phase ? b5 : b2;
    weight = b0[4] ? cfg.motion_weight : WEIGHT_W'(1);
    dxw    = $signed(dxb) * $signed({1'b0, weight});
    dyw    = $signed(dyb) * $signed({1'b0, weight});
  end

  // operation record
  always_comb begin
    op      = '0;
    op.last = 1'b1;
    if (trackpt) begin
      op.kind = KIND_TRACKPOINT;
    end else if (!sane) begin
      op.kind = KIND_UNKNOWN;
    end else begin
      case (ptype)
        PTYPE_STATUS: begin
          op.kind        = KIND_STATUS;
          op.finger_mask = b1[4:0];
        end
        PTYPE_HEAD: begin
          op.kind        = KIND_HEAD;
          op.pressure    = {b1[7:4], b4[7:4]};
          op.trace_width = b0[7:4];
          op.absolute    = 1'b1;
          op.dx          = {4'h0, b1[3:0], b2};
          op.dy          = POS_W'({4'h0, cfg.y_maximum}) - POS_W'({4'h0, b4[3:0], b5});
          if (field != '0) begin
            op.index = id;
            op.store = id < FC_CODE;
          end
        end
        PTYPE_MOTION: begin
          op.kind = KIND_MOTION;
          op.dx   = POS_W'(dxw);
          op.dy   = POS_W'(dyw);
          if (field != '0) begin
            op.index = id;
            op.store = id < FC_CODE;
          end
          if (!phase) begin
            op.last = (field == '0) || (b3[7:5] == '0);
          end
        end
        default: begin
          op.kind = KIND_UNKNOWN;
        end
      endcase
    end
  end

`ifndef SYNTH
  // the second word of a packet belongs only to a two-finger motion packet
  a_phase_motion: assert property (@(posedge clk) disable iff (rst)
    phase |-> (pk_valid && op.kind == KIND_MOTION))
    else $error("second word issued for a non-motion packet");
`endif

endmodule

// File: rtl/tpd_store.sv
// ----------------------------------------------------------------------------
// tpd_store: finger position memory with read-modify-write
// Reads the finger entry as an operation is issued, applies the absolute
// or delta update in the following cycle and writes it back. The last write is
// forwarded to a read of the same entry taken at the same edge.
// ----------------------------------------------------------------------------
module tpd_store import tpd_pkg::*; #(
  parameter int FINGER_COUNT = FINGER_COUNT_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  input  op_t  op,
  output logic res_valid,
  output res_t res
);

  localparam int AW = (FINGER_COUNT > 1) ? $clog2(FINGER_COUNT) : 1;
  localparam logic [IDX_W-1:0] FC_CODE = IDX_W'(FINGER_COUNT);

  logic [2*POS_W-1:0] mem [FINGER_COUNT];
  logic [FINGER_COUNT-1:0] vld;

  logic               s1_valid;
  op_t                s1_op;
  logic [2*POS_W-1:0] rd_data;
  logic               rd_vld;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [2*POS_W-1:0] wr_data;
  logic               fw_valid;
  logic [AW-1:0]      fw_addr;
  logic [2*POS_W-1:0] fw_data;

  logic [POS_W-1:0]   old_x, old_y, new_x, new_y;

  // read at issue, operation moves to the update stage
  always_ff @(posedge clk) begin
    if (op_valid) begin
      rd_data <= mem[op.index[AW-1:0]];
      rd_vld  <= vld[op.index[AW-1:0]];
      s1_op   <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= op_valid;
    end
  end

  // update stage: forward the previous write, then apply the operation
  always_comb begin
    if (fw_valid && fw_addr == s1_op.index[AW-1:0]) begin
      {old_x, old_y} = fw_data;
    end else if (rd_vld) begin
      {old_x, old_y} = rd_data;
    end else begin
      {old_x, old_y} = '0;
    end
    if (s1_op.absolute) begin
      new_x = s1_op.dx;
      new_y = s1_op.dy;
    end else begin
      new_x = old_x + s1_op.dx;
      new_y = old_y - s1_op.dy;
    end
    wr_en   = s1_valid && s1_op.store;
    wr_addr = s1_op.index[AW-1:0];
    wr_data = {new_x, new_y};
  end

  // write-back and valid bits
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      fw_valid <= 1'b0;
    end else begin
      fw_valid <= wr_en;
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fw_addr <= wr_addr;
      fw_data <= wr_data;
    end
  end

  // result word
  always_comb begin
    res_valid       = s1_valid;
    res.kind        = s1_op.kind;
    res.index       = s1_op.index;
    res.updated     = s1_op.store;
    res.pos_x       = s1_op.store ? new_x : '0;
    res.pos_y       = s1_op.store ? new_y : '0;
    res.pressure    = s1_op.pressure;
    res.trace_width = s1_op.trace_width;
    res.finger_mask = s1_op.finger_mask;
    res.last        = s1_op.last;
  end

`ifndef SYNTH
  // only fingers inside the store are ever written
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (s1_op.index < FC_CODE))
    else $error("write beyond finger store");
`endif

endmodule

// File: rtl/tpd_out_fifo.sv
// ----------------------------------------------------------------------------
// tpd_out_fifo: two-entry result queue
// Decouples the update stage from the receiver and grants issue credit
// so the update stage never has to stall.
// ----------------------------------------------------------------------------
module tpd_out_fifo import tpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_res,
  input  logic pop,
  output logic head_valid,
  output res_t head_res,
  output logic credit
);

  localparam int DEPTH = 2;

  res_t       fifo_mem [DEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count, count_next;

  assign count_next = count + {1'b0, push} - {1'b0, pop};
  assign credit     = count_next < 2'(DEPTH);
  assign head_valid = count != '0;
  assign head_res   = fifo_mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= push_res;
    end
  end

`ifndef SYNTH
  // the credit scheme must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count < 2'(DEPTH)))
    else $error("result queue overflow");

  // a word is only taken when one is held
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("result queue underflow");
`endif

endmodule

// File: rtl/touchpad_v4_packet_decoder_top.sv
// ----------------------------------------------------------------------------
// touchpad_v4_packet_decoder_top: six-byte touchpad packet decoder
// Usage:
//   pkt_in carries one six-byte packet per word; res_out returns one word per
//   result, two for a motion packet naming two fingers, the final one marked
//   by last_of_packet. Config registers are written through cfg_we,
//   cfg_index and cfg_wdata while no packet is in flight.
// Path: holding register, then update-stage register, then the result queue.
// Flow: a new packet is taken as the last word of the held one issues. The
//   finger memory read-modify-write handles one finger update per cycle while
//   the queue grants credit; a back-to-back update of one finger is forwarded.
// Reset (rst, synchronous): finger positions read as zero, config registers
//   return to their reset values, both channels go empty.
// Stalls: a two-word queue holds finished results while res_out is held off;
//   once it fills, issue stops and pkt_in.ready drops until words drain.
// ----------------------------------------------------------------------------
module touchpad_v4_packet_decoder_top import tpd_pkg::*; #(
  parameter int FINGER_COUNT = FINGER_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  tpd_in_if.sink               pkt_in,
  tpd_out_if.source            res_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t cfg;
  logic credit;
  logic op_valid;
  op_t  op;
  logic res_valid;
  res_t res;
  res_t head_res;
  logic pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{crc_mode: 1'b0, ic_body_version: '0, sample_byte_one: '0,
               trackpoint_present: 1'b0, y_maximum: '0,
               motion_weight: MOTION_WEIGHT_RST};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CRC_MODE:      cfg.crc_mode           <= cfg_wdata[0];
        CFG_IC_BODY_VER:   cfg.ic_body_version    <= cfg_wdata[3:0];
        CFG_SAMPLE_BYTE1:  cfg.sample_byte_one    <= cfg_wdata[BYTE_W-1:0];
        CFG_TRACKPOINT:    cfg.trackpoint_present <= cfg_wdata[0];
        CFG_Y_MAXIMUM:     cfg.y_maximum          <= cfg_wdata[YMAX_W-1:0];
        CFG_MOTION_WEIGHT: cfg.motion_weight      <= cfg_wdata[WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // classify and issue
  tpd_issue #(
    .FINGER_COUNT (FINGER_COUNT)
  ) u_issue (
    .clk      (clk),
    .rst      (rst),
    .pkt_in   (pkt_in),
    .cfg      (cfg),
    .credit   (credit),
    .op_valid (op_valid),
    .op       (op)
  );

  // finger memory update
  tpd_store #(
    .FINGER_COUNT (FINGER_COUNT)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op        (op),
    .res_valid (res_valid),
    .res       (res)
  );

  // result queue
  assign pop = res_out.valid && res_out.ready;

  tpd_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_res   (res),
    .pop        (pop),
    .head_valid (res_out.valid),
    .head_res   (head_res),
    .credit     (credit)
  );

  assign res_out.packet_kind      = head_res.kind;
  assign res_out.finger_index     = head_res.index;
  assign res_out.position_updated = head_res.updated;
  assign res_out.pos_x            = head_res.pos_x;
  assign res_out.pos_y            = head_res.pos_y;
  assign res_out.pressure         = head_res.pressure;
  assign res_out.trace_width      = head_res.trace_width;
  assign res_out.finger_mask      = head_res.finger_mask;
  assign res_out.last_of_packet   = head_res.last;

endmodule
